// File: rtl/core/qasa_pkg.sv
// qasa_pkg: shared types, constants and codes for the quad adc scaling block
// no dependencies; imported by every module in rtl/core
package qasa_pkg;

  // channel and field sizes
  localparam int unsigned CHANNELS   = 4;
  localparam int unsigned CH_IDX_W   = $clog2(CHANNELS);
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned K_W        = 15;
  localparam int unsigned DIVIDEND_W = SAMPLE_W + K_W;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;

  // scale factors: 1.079 * 65535 / 5.1 and 1.079 * 65535 / 2.55, truncated
  localparam logic [K_W-1:0] K_WIDE   = K_W'(13865);
  localparam logic [K_W-1:0] K_NARROW = K_W'(27730);

  // divider: quotient bits retired per cycle and cycles per division
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_CYCLES = SAMPLE_W / DIV_STEPS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SELECT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_HI_EN  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_LO_EN  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR      = CFG_IDX_W'(4);

  typedef struct packed {
    logic [CHANNELS-1:0] channel_select;
    logic [SAMPLE_W-1:0] reference_sample;
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
    logic [SAMPLE_W-1:0] sample_c;
    logic [SAMPLE_W-1:0] sample_d;
  } in_word_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] result_a;
    logic [SAMPLE_W-1:0] result_b;
    logic [SAMPLE_W-1:0] result_c;
    logic [SAMPLE_W-1:0] result_d;
    logic [CHANNELS-1:0] high_alarms;
    logic [CHANNELS-1:0] low_alarms;
    logic                alarm_raised;
  } out_word_t;

  typedef struct packed {
    logic [CHANNELS-1:0]       range_select;
    logic [CHANNELS-1:0]       alarm_high_enable;
    logic [CHANNELS-1:0]       alarm_low_enable;
    logic [CHANNELS*THR_W-1:0] high_thresholds;
    logic [CHANNELS*THR_W-1:0] low_thresholds;
  } cfg_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [SAMPLE_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [SAMPLE_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINISH
  } seq_state_e;

endpackage

// File: rtl/core/quad_adc_scale_and_alarm.sv
// quad_adc_scale_and_alarm: top level with config registers and output register
// depends on qasa_pkg, qasa_div and qasa_seq
//
//   port group   direction  handshake              word
//   in           input      in_valid_i/in_ready_o  in_word_i
//   out          output     out_valid_o/out_ready_i out_word_o
//   cfg          input      cfg_we_i (no wait)      cfg_idx_i, cfg_wdata_i
//
// one word goes through idle and finish once, a scan step per unselected channel
// and, per selected channel, scan, multiply, divider start, the radix-16 divider
// iterations and store; the shared divider serves the channels in turn.
// reset clears stored values, alarm flags and config to their defaults.
// a finished word waits in the output register; the next word is taken
// meanwhile and only its own completion waits for the register to drain.
module quad_adc_scale_and_alarm (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  qasa_pkg::in_word_t                   in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output qasa_pkg::out_word_t                  out_word_o,
  input  logic                                 cfg_we_i,
  input  logic [qasa_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [qasa_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import qasa_pkg::*;

  cfg_t      cfg_q;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  logic      out_valid_q, out_valid_d;
  out_word_t out_q;
  logic      out_free;
  logic      fin;
  out_word_t fin_word;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_select      <= '0;
      cfg_q.alarm_high_enable <= '1;
      cfg_q.alarm_low_enable  <= '1;
      cfg_q.high_thresholds   <= '1;
      cfg_q.low_thresholds    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RANGE_SELECT: cfg_q.range_select      <= cfg_wdata_i[CHANNELS-1:0];
        REG_ALARM_HI_EN:  cfg_q.alarm_high_enable <= cfg_wdata_i[CHANNELS-1:0];
        REG_ALARM_LO_EN:  cfg_q.alarm_low_enable  <= cfg_wdata_i[CHANNELS-1:0];
        REG_HIGH_THR:     cfg_q.high_thresholds   <= cfg_wdata_i[CHANNELS*THR_W-1:0];
        REG_LOW_THR:      cfg_q.low_thresholds    <= cfg_wdata_i[CHANNELS*THR_W-1:0];
        default: ;
      endcase
    end
  end

  qasa_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .cfg_i      (cfg_q),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp),
    .out_free_i (out_free),
    .fin_o      (fin),
    .fin_word_o (fin_word)
  );

  qasa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // output register
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (fin) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) out_q <= fin_word;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef ASSERT_OFF
  // one word at a time: a taken word closes the input
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again straight after a word");

  // divider is never restarted while it is running
  a_div_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (!div_rsp.busy && !div_rsp.done))
    else $error("divider started while busy");

  // a started division runs
  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> div_rsp.busy)
    else $error("divider did not start");

  // raised alarm implies a flag is set
  a_raised_has_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.alarm_raised) |->
      ((out_word_o.high_alarms | out_word_o.low_alarms) != '0))
    else $error("alarm raised with no flag set");
`endif

endmodule

// File: rtl/core/qasa_div.sv
// qasa_div: shared saturating divider, four quotient bits per cycle
// depends on qasa_pkg
module qasa_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qasa_pkg::div_req_t req_i,
  output qasa_pkg::div_rsp_t rsp_o
);
  import qasa_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 sat_q;
  logic [SAMPLE_W-1:0]  rem_q, rem_d;
  logic [SAMPLE_W-1:0]  lo_q, lo_d;
  logic [SAMPLE_W-1:0]  quot_q, quot_d;
  logic [SAMPLE_W-1:0]  div_q;
  logic                 sat_d;

  // quotient above full scale (or zero divisor) saturates
  assign sat_d = {1'b0, req_i.dividend} >= {req_i.divisor, SAMPLE_W'(0)};

  // four restoring steps per cycle
  always_comb begin
    logic [SAMPLE_W:0]   r;
    logic [SAMPLE_W-1:0] rem_v;
    logic [SAMPLE_W-1:0] lo_v;
    logic [SAMPLE_W-1:0] q_v;
    rem_v = rem_q;
    lo_v  = lo_q;
    q_v   = quot_q;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r    = {rem_v, lo_v[SAMPLE_W-1]};
      lo_v = {lo_v[SAMPLE_W-2:0], 1'b0};
      if (r >= {1'b0, div_q}) begin
        r   = r - {1'b0, div_q};
        q_v = {q_v[SAMPLE_W-2:0], 1'b1};
      end else begin
        q_v = {q_v[SAMPLE_W-2:0], 1'b0};
      end
      rem_v = r[SAMPLE_W-1:0];
    end
    rem_d = rem_v;
    lo_d  = lo_v;
    quot_d = q_v;
  end

  // iteration control
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath: upper bits seed the remainder, lower bits shift in
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sat_q  <= sat_d;
      rem_q  <= SAMPLE_W'(req_i.dividend[DIVIDEND_W-1:SAMPLE_W]);
      lo_q   <= req_i.dividend[SAMPLE_W-1:0];
      quot_q <= '0;
      div_q  <= req_i.divisor;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      lo_q   <= lo_d;
      quot_q <= quot_d;
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = sat_q ? '1 : quot_q;

endmodule

// File: rtl/core/qasa_seq.sv
// qasa_seq: per-channel sequencer, multiplier, stored values and alarm flags
// depends on qasa_pkg; drives the shared divider qasa_div
module qasa_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  qasa_pkg::in_word_t  in_word_i,
  input  qasa_pkg::cfg_t      cfg_i,
  output qasa_pkg::div_req_t  div_req_o,
  input  qasa_pkg::div_rsp_t  div_rsp_i,
  input  logic                out_free_i,
  output logic                fin_o,
  output qasa_pkg::out_word_t fin_word_o
);
  import qasa_pkg::*;

  localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(CHANNELS - 1);

  seq_state_e state_q, state_d;
  logic [CH_IDX_W-1:0] idx_q, idx_d;
  logic                raised_q, raised_d;
  logic [CHANNELS-1:0] hi_q, hi_d;
  logic [CHANNELS-1:0] lo_q, lo_d;
  logic [SAMPLE_W-1:0] vals_q [CHANNELS];
  in_word_t            item_q;
  logic [DIVIDEND_W-1:0] prod_q;

  logic                item_we, prod_we, val_we;
  logic                div_start;
  logic [SAMPLE_W-1:0] sample [CHANNELS];
  logic [K_W-1:0]      k_sel;
  logic [THR_W-1:0]    upper, hi_thr, lo_thr;
  logic                hit_hi, hit_lo;

  // current channel's operands
  assign sample[0] = item_q.sample_a;
  assign sample[1] = item_q.sample_b;
  assign sample[2] = item_q.sample_c;
  assign sample[3] = item_q.sample_d;
  assign k_sel     = cfg_i.range_select[idx_q] ? K_WIDE : K_NARROW;

  // threshold compare on the upper byte of the fresh quotient
  assign upper  = div_rsp_i.quotient[SAMPLE_W-1 -: THR_W];
  assign hi_thr = cfg_i.high_thresholds[{idx_q, 3'b000} +: THR_W];
  assign lo_thr = cfg_i.low_thresholds[{idx_q, 3'b000} +: THR_W];
  assign hit_hi = cfg_i.alarm_high_enable[idx_q] && (upper > hi_thr);
  assign hit_lo = cfg_i.alarm_low_enable[idx_q] && (upper < lo_thr);

  assign div_req_o.start    = div_start;
  assign div_req_o.dividend = prod_q;
  assign div_req_o.divisor  = item_q.reference_sample;

  // next state and outputs
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    raised_d   = raised_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    item_we    = 1'b0;
    prod_we    = 1'b0;
    val_we     = 1'b0;
    in_ready_o = 1'b0;
    fin_o      = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_we  = 1'b1;
          idx_d    = '0;
          raised_d = 1'b0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (item_q.channel_select[idx_q]) begin
          state_d = ST_MUL;
        end else if (idx_q == LAST_CH) begin
          state_d = ST_FINISH;
        end else begin
          idx_d = idx_q + CH_IDX_W'(1);
        end
      end
      ST_MUL: begin
        prod_we = 1'b1;
        state_d = ST_DIV_START;
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp_i.done) begin
          val_we = 1'b1;
          if (hit_hi) hi_d[idx_q] = 1'b1;
          if (hit_lo) lo_d[idx_q] = 1'b1;
          raised_d = raised_q | hit_hi | hit_lo;
          if (idx_q == LAST_CH) begin
            state_d = ST_FINISH;
          end else begin
            idx_d   = idx_q + CH_IDX_W'(1);
            state_d = ST_SCAN;
          end
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          fin_o   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state, stored values and sticky flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      raised_q <= 1'b0;
      hi_q     <= '0;
      lo_q     <= '0;
      for (int i = 0; i < CHANNELS; i++) vals_q[i] <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      raised_q <= raised_d;
      hi_q     <= hi_d;
      lo_q     <= lo_d;
      if (val_we) vals_q[idx_q] <= div_rsp_i.quotient;
    end
  end

  // captured word and registered product
  always_ff @(posedge clk_i) begin
    if (item_we) item_q <= in_word_i;
    if (prod_we) prod_q <= DIVIDEND_W'(sample[idx_q]) * DIVIDEND_W'(k_sel);
  end

  // result word
  assign fin_word_o.result_a     = vals_q[0];
  assign fin_word_o.result_b     = vals_q[1];
  assign fin_word_o.result_c     = vals_q[2];
  assign fin_word_o.result_d     = vals_q[3];
  assign fin_word_o.high_alarms  = hi_q;
  assign fin_word_o.low_alarms   = lo_q;
  assign fin_word_o.alarm_raised = raised_q;

endmodule
